FILE: rtl/core/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types, operation codes and pin scatter tables for the LED matrix
// frame scanner.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  localparam int ROWS      = 8;
  localparam int ROW_W     = 8;
  localparam int ROW_IDX_W = 3;

  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_SET   = 3'd1,
    FUNC_CLR   = 3'd2,
    FUNC_TGL   = 3'd3,
    FUNC_WRITE = 3'd4,
    FUNC_READ  = 3'd5
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // write request into the frame memory
  typedef struct packed {
    logic                 we;
    logic [ROW_IDX_W-1:0] addr;
    logic [ROW_W-1:0]     data;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
  } pins_t;

  // entry i: 1-based source bit that drives port bit i, 0 = tied low
  typedef logic [3:0] pin_tab_t [8];

  localparam pin_tab_t COL_TAB_B = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd4, 4'd0, 4'd0};
  localparam pin_tab_t COL_TAB_C = '{4'd0, 4'd0, 4'd1, 4'd0, 4'd3, 4'd6, 4'd0, 4'd0};
  localparam pin_tab_t ROW_TAB_C = '{4'd2, 4'd3, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0};
  localparam pin_tab_t COL_TAB_D = '{4'd7, 4'd0, 4'd5, 4'd0, 4'd0, 4'd8, 4'd0, 4'd0};
  localparam pin_tab_t ROW_TAB_D = '{4'd0, 4'd1, 4'd0, 4'd6, 4'd4, 4'd0, 4'd8, 4'd7};

  function automatic logic [7:0] scatter(input logic [7:0] src, input pin_tab_t tab);
    logic [7:0] r;
    logic [3:0] from;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      from = tab[i];
      if (from >= 4'd1 && from <= 4'd8) begin
        r[i] = src[3'(from - 4'd1)];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/led_matrix_frame_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_scanner
// 8x8 LED matrix controller: frame edits, cell reads and row scan ticks.
//
//   channel  | signals                                     | handshake
//   ---------+---------------------------------------------+-----------------
//   command  | func, row_index, column_index, row_data     | start & !busy
//   result   | port_b, port_c, port_d, cell_value          | done (1 cycle)
//
// Each transaction first reads the frame row from the frame memory (a
// registered read), then modifies it, writes it back and registers the
// result. busy is high only in that modify and write-back cycle; done pulses
// in the following cycle, in which a new command can already be taken.
// Synchronous reset clears the scan row, the ports and the frame valid flags.
// The receiver cannot stall; ports hold between scan ticks.
// ----------------------------------------------------------------------------
module led_matrix_frame_scanner (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] func,
  input  logic [2:0] row_index,
  input  logic [2:0] column_index,
  input  logic [7:0] row_data,
  output logic       done,
  output logic [7:0] port_b,
  output logic [7:0] port_c,
  output logic [7:0] port_d,
  output logic       cell_value
);
  import lmfs_pkg::*;

  state_t state, state_next;

  logic [2:0]           func_q;
  logic [2:0]           row_q;
  logic [2:0]           col_q;
  logic [7:0]           data_q;
  logic [ROW_IDX_W-1:0] scan_row;

  logic                 accept;
  logic                 rd_en;
  logic [ROW_IDX_W-1:0] rd_addr;
  logic [ROW_W-1:0]     rd_data;
  mem_wr_t              wr;
  pins_t                pins;
  logic [7:0]           mask;

  assign accept  = start && !busy;
  assign rd_addr = (func == FUNC_TICK) ? scan_row : row_index;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy  = 1'b0;
    rd_en = 1'b0;
    case (state)
      ST_IDLE: rd_en = start;
      ST_EXEC: busy  = 1'b1;
      default: busy  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      row_q  <= row_index;
      col_q  <= column_index;
      data_q <= row_data;
    end
  end

  // read-modify-write of the addressed row
  assign mask = 8'h80 >> col_q;

  always_comb begin
    wr.we   = 1'b0;
    wr.addr = row_q;
    wr.data = rd_data;
    case (func_q)
      FUNC_SET:   wr.data = rd_data | mask;
      FUNC_CLR:   wr.data = rd_data & ~mask;
      FUNC_TGL:   wr.data = rd_data ^ mask;
      FUNC_WRITE: wr.data = data_q;
      default:    wr.data = rd_data;
    endcase
    if (busy && (func_q == FUNC_SET || func_q == FUNC_CLR ||
                 func_q == FUNC_TGL || func_q == FUNC_WRITE)) begin
      wr.we = 1'b1;
    end
  end

  lmfs_frame_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  lmfs_pin_map u_pins (
    .row_byte (rd_data),
    .scan_row (scan_row),
    .pins     (pins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      scan_row   <= '0;
      port_b     <= '0;
      port_c     <= '0;
      port_d     <= '0;
      cell_value <= 1'b0;
    end else begin
      done <= busy;
      if (busy) begin
        cell_value <= (func_q == FUNC_READ) ? rd_data[3'd7 - col_q] : 1'b0;
        if (func_q == FUNC_TICK) begin
          port_b   <= pins.b;
          port_c   <= pins.c;
          port_d   <= pins.d;
          scan_row <= scan_row + 1'b1;
        end
      end
    end
  end

  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without a preceding execute cycle");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("execute phase longer than one cycle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted transaction did not enter execute");

  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    (busy && func_q == FUNC_TICK) |=> scan_row == $past(scan_row) + 3'd1)
    else $error("scan row did not advance on tick");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (busy && (func_q == FUNC_READ || func_q == FUNC_TICK)) |-> !wr.we)
    else $error("frame written on read or tick");

endmodule

FILE: rtl/core/lmfs_frame_mem.sv
// ----------------------------------------------------------------------------
// lmfs_frame_mem
// Frame store: eight row bytes, one write and one registered read per cycle.
// Per-row valid flags make unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module lmfs_frame_mem (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rd_en,
  input  logic [lmfs_pkg::ROW_IDX_W-1:0]   rd_addr,
  output logic [lmfs_pkg::ROW_W-1:0]       rd_data,
  input  lmfs_pkg::mem_wr_t                wr
);
  import lmfs_pkg::*;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [ROW_W-1:0] mem_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr.we) begin
        row_valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

FILE: rtl/core/lmfs_pin_map.sv
// ----------------------------------------------------------------------------
// lmfs_pin_map
// Scatters the inverted row byte and the one-hot scan row bit onto the
// three port bytes through the fixed pin tables.
// ----------------------------------------------------------------------------
module lmfs_pin_map (
  input  logic [lmfs_pkg::ROW_W-1:0]     row_byte,
  input  logic [lmfs_pkg::ROW_IDX_W-1:0] scan_row,
  output lmfs_pkg::pins_t                pins
);
  import lmfs_pkg::*;

  logic [7:0] cols;
  logic [7:0] rows;

  // a lit cell pulls its column low
  assign cols = ~row_byte;
  assign rows = 8'd1 << scan_row;

  assign pins.b = scatter(cols, COL_TAB_B);
  assign pins.c = scatter(cols, COL_TAB_C) | scatter(rows, ROW_TAB_C);
  assign pins.d = scatter(cols, COL_TAB_D) | scatter(rows, ROW_TAB_D);

endmodule

FILE: verif/led_matrix_frame_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_matrix_frame_scanner_tb
// Self-checking bench: commands go in through start/busy, and every done
// strobe is compared with a frame and scan model kept inside the bench.
// Directed cases come first, then random traffic with varied sender gaps.
// ----------------------------------------------------------------------------
module led_matrix_frame_scanner_tb;
  import lmfs_pkg::*;

  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  // port bit i <- source bit (entry - 1); entry 0 ties the bit low
  typedef int unsigned pin_map_t [8];
  localparam pin_map_t B_COL_MAP = '{0, 0, 0, 0, 2, 4, 0, 0};
  localparam pin_map_t C_COL_MAP = '{0, 0, 1, 0, 3, 6, 0, 0};
  localparam pin_map_t C_ROW_MAP = '{2, 3, 0, 5, 0, 0, 0, 0};
  localparam pin_map_t D_COL_MAP = '{7, 0, 5, 0, 0, 8, 0, 0};
  localparam pin_map_t D_ROW_MAP = '{0, 1, 0, 6, 4, 0, 8, 7};

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic       cell_bit;
  } port_image_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] func = '0;
  logic [2:0] row_index = '0;
  logic [2:0] column_index = '0;
  logic [7:0] row_data = '0;
  logic       busy;
  logic       done;
  logic [7:0] port_b;
  logic [7:0] port_c;
  logic [7:0] port_d;
  logic       cell_value;

  // model of the frame, scan pointer and pin latches
  logic [7:0] frame_model [8];
  logic [2:0] scan_model;
  logic [7:0] pin_b_model;
  logic [7:0] pin_c_model;
  logic [7:0] pin_d_model;

  port_image_t port_image_q [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  logic [2:0]  last_row = '0;

  led_matrix_frame_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .row_index    (row_index),
    .column_index (column_index),
    .row_data     (row_data),
    .done         (done),
    .port_b       (port_b),
    .port_c       (port_c),
    .port_d       (port_d),
    .cell_value   (cell_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] route_pins(input logic [7:0] src, input pin_map_t map);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (map[i] != 0) r[i] = src[map[i] - 1];
    end
    return r;
  endfunction

  function automatic port_image_t matrix_step(input logic [2:0] f, input logic [2:0] r,
                                              input logic [2:0] c, input logic [7:0] d);
    logic [7:0] mask;
    logic [7:0] cols;
    logic [7:0] row_sel;
    port_image_t img;
    mask = 8'h80 >> c;
    img.cell_bit = 1'b0;
    case (f)
      FUNC_TICK: begin
        // lit cell pulls its column low
        cols = ~frame_model[scan_model];
        row_sel = 8'h01 << scan_model;
        pin_b_model = route_pins(cols, B_COL_MAP);
        pin_c_model = route_pins(cols, C_COL_MAP) | route_pins(row_sel, C_ROW_MAP);
        pin_d_model = route_pins(cols, D_COL_MAP) | route_pins(row_sel, D_ROW_MAP);
        scan_model = scan_model + 3'd1;
      end
      FUNC_SET:   frame_model[r] = frame_model[r] | mask;
      FUNC_CLR:   frame_model[r] = frame_model[r] & ~mask;
      FUNC_TGL:   frame_model[r] = frame_model[r] ^ mask;
      FUNC_WRITE: frame_model[r] = d;
      FUNC_READ:  img.cell_bit = frame_model[r][3'd7 - c];
      default: ;
    endcase
    img.b = pin_b_model;
    img.c = pin_c_model;
    img.d = pin_d_model;
    return img;
  endfunction

  // call right after a falling edge; returns right after a falling edge, once the command is taken
  task automatic send_cmd(input logic [2:0] f, input logic [2:0] r,
                          input logic [2:0] c, input logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    func         <= f;
    row_index    <= r;
    column_index <= c;
    row_data     <= d;
    do @(posedge clk); while (busy);
    port_image_q.push_back(matrix_step(f, r, c, d));
    last_row = r;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    port_image_t want;
    if (!rst && done) begin
      if (port_image_q.size() == 0) begin
        mismatch_count++;
        $error("done strobe with no pending transaction");
      end else begin
        want = port_image_q.pop_front();
        if (port_b !== want.b) begin
          mismatch_count++;
          $error("port_b: expected %h, got %h", want.b, port_b);
        end
        if (port_c !== want.c) begin
          mismatch_count++;
          $error("port_c: expected %h, got %h", want.c, port_c);
        end
        if (port_d !== want.d) begin
          mismatch_count++;
          $error("port_d: expected %h, got %h", want.d, port_d);
        end
        if (cell_value !== want.cell_bit) begin
          mismatch_count++;
          $error("cell_value: expected %b, got %b", want.cell_bit, cell_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_power_up();
    send_cmd(FUNC_READ, 3'd0, 3'd0, 8'h00);
    send_cmd(FUNC_READ, 3'd7, 3'd7, 8'hFF);
    send_cmd(FUNC_TICK, 3'd0, 3'd0, 8'h00);
  endtask

  task automatic test_cell_edits();
    send_cmd(FUNC_SET,  3'd0, 3'd0, 8'h00);
    send_cmd(FUNC_SET,  3'd7, 3'd7, 8'hFF);
    send_cmd(FUNC_READ, 3'd0, 3'd0, 8'h00);
    send_cmd(FUNC_READ, 3'd7, 3'd7, 8'h00);
    send_cmd(FUNC_TGL,  3'd0, 3'd0, 8'h00);
    send_cmd(FUNC_READ, 3'd0, 3'd0, 8'h00);
    send_cmd(FUNC_CLR,  3'd7, 3'd7, 8'h00);
    send_cmd(FUNC_READ, 3'd7, 3'd7, 8'h00);
  endtask

  // rows 1 and 7 lit, then a full scan that wraps the row pointer
  task automatic test_row_scan();
    send_cmd(FUNC_WRITE, 3'd1, 3'd0, 8'hFF);
    send_cmd(FUNC_WRITE, 3'd7, 3'd5, 8'hA5);
    send_cmd(FUNC_WRITE, 3'd2, 3'd3, 8'h00);
    repeat (8) send_cmd(FUNC_TICK, 3'd7, 3'd7, 8'hFF);
  endtask

  task automatic test_spare_codes();
    send_cmd(FUNC_SPARE_6, 3'd1, 3'd0, 8'h5A);
    send_cmd(FUNC_SPARE_7, 3'd7, 3'd7, 8'hFF);
  endtask

  task automatic test_random_traffic(input int n_items, input int pct);
    logic [2:0] f;
    logic [2:0] r;
    logic [7:0] d;
    int         pick;
    idle_pct = pct;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 28)      f = FUNC_TICK;
      else if (pick < 40) f = FUNC_SET;
      else if (pick < 50) f = FUNC_CLR;
      else if (pick < 60) f = FUNC_TGL;
      else if (pick < 73) f = FUNC_WRITE;
      else if (pick < 96) f = FUNC_READ;
      else                f = $urandom_range(1) ? FUNC_SPARE_7 : FUNC_SPARE_6;
      // reusing the row hits back-to-back read-modify-write on one entry
      r = $urandom_range(1) ? last_row : 3'($urandom_range(7));
      case ($urandom_range(7))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      send_cmd(f, r, 3'($urandom_range(7)), d);
    end
    idle_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) frame_model[i] = '0;
    scan_model  = '0;
    pin_b_model = '0;
    pin_c_model = '0;
    pin_d_model = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_power_up();
    test_cell_edits();
    test_row_scan();
    test_spare_codes();
    test_random_traffic(520, 0);
    test_random_traffic(520, 46);
    test_random_traffic(510, 8);

    start <= 1'b0;
    while (port_image_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
